// File: src/mmc3c_pkg.sv
// Shared types and constants for the MMC3-style clone mapper core.
// Used by mmc3_clone_bank_mapper_irq_core and its checker; depends on nothing.
package mmc3c_pkg;

    // Register decode: address bits 15:13 and 0 select the register.
    localparam logic [15:0] DEC_MASK       = 16'hE001;
    localparam logic [15:0] DEC_BANK_SEL   = 16'h8000;
    localparam logic [15:0] DEC_BANK_DATA  = 16'h8001;
    localparam logic [15:0] DEC_MIRROR     = 16'hA000;
    localparam logic [15:0] DEC_IRQ_LATCH  = 16'hC000;
    localparam logic [15:0] DEC_IRQ_RELOAD = 16'hC001;
    localparam logic [15:0] DEC_IRQ_DIS    = 16'hE000;
    localparam logic [15:0] DEC_IRQ_EN     = 16'hE001;

    // Result kinds.
    localparam logic [1:0] KIND_PRG = 2'd0;
    localparam logic [1:0] KIND_CHR = 2'd1;
    localparam logic [1:0] KIND_MIR = 2'd2;
    localparam logic [1:0] KIND_IRQ = 2'd3;

    // Mirroring codes.
    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_FOUR       = 2'd2;

    // Bank-select mode codes (low three bits of the bank-select register).
    localparam logic [2:0] SEL_CHR_2K_0 = 3'd0;
    localparam logic [2:0] SEL_CHR_2K_1 = 3'd1;
    localparam logic [2:0] SEL_CHR_1K_2 = 3'd2;
    localparam logic [2:0] SEL_CHR_1K_3 = 3'd3;
    localparam logic [2:0] SEL_CHR_1K_4 = 3'd4;
    localparam logic [2:0] SEL_CHR_1K_5 = 3'd5;
    localparam logic [2:0] SEL_PRG_SWAP = 3'd6;
    localparam logic [2:0] SEL_PRG_A000 = 3'd7;

    // Window addresses.
    localparam logic [15:0] WIN_CHR_HALF = 16'h1000;
    localparam logic [15:0] WIN_CHR_0    = 16'h0000;
    localparam logic [15:0] WIN_CHR_1    = 16'h0400;
    localparam logic [15:0] WIN_CHR_2    = 16'h0800;
    localparam logic [15:0] WIN_CHR_3    = 16'h0C00;
    localparam logic [15:0] WIN_CHR_4    = 16'h1000;
    localparam logic [15:0] WIN_CHR_5    = 16'h1400;
    localparam logic [15:0] WIN_CHR_6    = 16'h1800;
    localparam logic [15:0] WIN_CHR_7    = 16'h1C00;
    localparam logic [15:0] WIN_PRG_8000 = 16'h8000;
    localparam logic [15:0] WIN_PRG_A000 = 16'hA000;
    localparam logic [15:0] WIN_PRG_C000 = 16'hC000;

    localparam logic [8:0] LAST_IRQ_LINE = 9'd240;

    // Configuration register indexes and reset values.
    localparam logic REG_PRG_BANK_COUNT = 1'b0;
    localparam logic REG_FOUR_SCREEN    = 1'b1;
    localparam logic [8:0] PRG_BANK_COUNT_RST = 9'd32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] window_address;
        logic [7:0]  bank_number;
        logic        chr_in_ram;
        logic [1:0]  mirroring;
        logic        last;
    } t_result;

    localparam t_result RESULT_NONE = '0;

    // A 1 KB CHR mapping; the lowest four banks live in CHR RAM.
    function automatic t_result chr_result(input logic [15:0] win, input logic [7:0] bank);
        t_result r;
        r                = RESULT_NONE;
        r.kind           = KIND_CHR;
        r.window_address = win;
        r.bank_number    = bank;
        r.chr_in_ram     = (bank[7:2] == 6'd0);
        return r;
    endfunction

    function automatic t_result prg_result(input logic [15:0] win, input logic [7:0] bank);
        t_result r;
        r                = RESULT_NONE;
        r.kind           = KIND_PRG;
        r.window_address = win;
        r.bank_number    = bank;
        return r;
    endfunction

endpackage

// File: src/mmc3_clone_bank_mapper_irq_core.sv
// Top level of the MMC3-style clone mapper: register decode, scanline IRQ
// counter and the result queue. Depends on mmc3c_pkg.
//
// Usage: the input channel (i_valid / o_stall) carries one beat per CPU
// register write (i_operation 0) or end-of-scanline tick (i_operation 1).
// A beat is taken at a rising edge with i_valid high and o_stall low. Each
// beat yields zero, one or two result beats on the output channel
// (o_valid / i_stall); o_last marks the final result of an input beat.
// Bank-data writes in the 2 KB CHR modes yield two CHR beats, IRQ latch,
// reload, enable and disable writes, unhandled addresses and ticks past
// line 240 or with rendering off yield none.
// Throughput: one input beat per cycle while o_stall is low; the state update
// and result decode are a single level of logic in front of a small result
// queue, so the sustained rate is set by the output port, which moves one
// result a cycle while i_stall is low. The queue holds P_FIFO_DEPTH results;
// o_stall rises while fewer than two entries are free, so a stalled receiver
// backs the input up after a few beats without any result being lost.
// Stalled results hold steady. Reset (i_rst_n low, synchronous) empties the
// queue, clears the mapper state and sets prg_bank_count to 32 and four_screen
// to 0. The APB port writes prg_bank_count at 0x0 and four_screen at 0x4; the
// user must do so only while the core is idle; the block does not enforce it.
module mmc3_clone_bank_mapper_irq_core
    import mmc3c_pkg::*;
#(
    parameter int P_FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_value,
    input  logic [8:0]  i_scanline,
    input  logic        i_rendering_on,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_window_address,
    output logic [7:0]  o_bank_number,
    output logic        o_chr_in_ram,
    output logic [1:0]  o_mirroring,
    output logic        o_last,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Queue depth must be a power of two and at least two.
    localparam int PTR_W = $clog2(P_FIFO_DEPTH);
    localparam int CNT_W = $clog2(P_FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] STALL_LEVEL = CNT_W'(P_FIFO_DEPTH - 2);

    // Configuration registers.
    logic [8:0] r_prg_bank_count;
    logic       r_four_screen;

    // Mapper state. Bit 7 of bank select is the CHR inversion flag.
    logic [7:0] r_bank_select, n_bank_select;
    logic [7:0] r_irq_counter, n_irq_counter;
    logic [7:0] r_irq_latch, n_irq_latch;
    logic       r_irq_enabled, n_irq_enabled;

    // Result queue.
    t_result          r_fifo [P_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    t_result    n_res0, n_res1;
    logic [1:0] n_nres;
    logic       in_acc, out_acc, cfg_wr;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_count > STALL_LEVEL);
    assign o_valid = (r_count != '0);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_FOUR_SCREEN) ? {31'd0, r_four_screen}
                                                  : {23'd0, r_prg_bank_count};

    // Decode of one input beat: next state plus up to two results.
    always_comb begin
        logic [15:0] dec;
        logic [15:0] chr_base;
        logic [7:0]  even_bank;
        logic [7:0]  tick_count;

        dec        = i_address & DEC_MASK;
        chr_base   = r_bank_select[7] ? WIN_CHR_HALF : 16'h0000;
        even_bank  = {i_value[7:1], 1'b0};
        tick_count = (r_irq_counter == 8'd0) ? r_irq_latch : (r_irq_counter - 8'd1);

        n_bank_select = r_bank_select;
        n_irq_counter = r_irq_counter;
        n_irq_latch   = r_irq_latch;
        n_irq_enabled = r_irq_enabled;
        n_res0        = RESULT_NONE;
        n_res1        = RESULT_NONE;
        n_nres        = 2'd0;

        if (i_operation) begin
            if (i_scanline <= LAST_IRQ_LINE && i_rendering_on) begin
                n_irq_counter = tick_count;
                if (r_irq_enabled && tick_count == 8'd0) begin
                    n_res0.kind = KIND_IRQ;
                    n_nres      = 2'd1;
                end
            end
        end else begin
            unique case (dec)
                DEC_BANK_SEL: begin
                    n_bank_select = i_value;
                    n_res0 = prg_result(i_value[6] ? WIN_PRG_8000 : WIN_PRG_C000,
                                        r_prg_bank_count[7:0] - 8'd2);
                    n_nres = 2'd1;
                end
                DEC_BANK_DATA: begin
                    n_nres = 2'd1;
                    unique case (r_bank_select[2:0])
                        SEL_CHR_2K_0: begin
                            n_res0 = chr_result(chr_base ^ WIN_CHR_0, even_bank);
                            n_res1 = chr_result(chr_base ^ WIN_CHR_1, even_bank | 8'd1);
                            n_nres = 2'd2;
                        end
                        SEL_CHR_2K_1: begin
                            n_res0 = chr_result(chr_base ^ WIN_CHR_2, even_bank);
                            n_res1 = chr_result(chr_base ^ WIN_CHR_3, even_bank | 8'd1);
                            n_nres = 2'd2;
                        end
                        SEL_CHR_1K_2: n_res0 = chr_result(chr_base ^ WIN_CHR_4, i_value);
                        SEL_CHR_1K_3: n_res0 = chr_result(chr_base ^ WIN_CHR_5, i_value);
                        SEL_CHR_1K_4: n_res0 = chr_result(chr_base ^ WIN_CHR_6, i_value);
                        SEL_CHR_1K_5: n_res0 = chr_result(chr_base ^ WIN_CHR_7, i_value);
                        SEL_PRG_SWAP: n_res0 = prg_result(
                            r_bank_select[6] ? WIN_PRG_C000 : WIN_PRG_8000, i_value);
                        SEL_PRG_A000: n_res0 = prg_result(WIN_PRG_A000, i_value);
                        default:      n_res0 = RESULT_NONE;
                    endcase
                end
                DEC_MIRROR: begin
                    n_res0.kind      = KIND_MIR;
                    n_res0.mirroring = r_four_screen ? MIR_FOUR
                                     : (i_value[0] ? MIR_HORIZONTAL : MIR_VERTICAL);
                    n_nres           = 2'd1;
                end
                DEC_IRQ_LATCH:  n_irq_latch   = i_value;
                DEC_IRQ_RELOAD: n_irq_counter = 8'd0;
                DEC_IRQ_DIS:    n_irq_enabled = 1'b0;
                DEC_IRQ_EN:     n_irq_enabled = 1'b1;
                default: begin
                    n_nres = 2'd0;
                end
            endcase
        end

        n_res0.last = (n_nres == 2'd1);
        n_res1.last = 1'b1;
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank_count <= PRG_BANK_COUNT_RST;
            r_four_screen    <= 1'b0;
            r_bank_select    <= 8'd0;
            r_irq_counter    <= 8'd0;
            r_irq_latch      <= 8'd0;
            r_irq_enabled    <= 1'b0;
            r_wr_ptr         <= '0;
            r_rd_ptr         <= '0;
            r_count          <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_PRG_BANK_COUNT) begin
                    r_prg_bank_count <= pwdata[8:0];
                end else begin
                    r_four_screen <= pwdata[0];
                end
            end
            if (in_acc) begin
                r_bank_select <= n_bank_select;
                r_irq_counter <= n_irq_counter;
                r_irq_latch   <= n_irq_latch;
                r_irq_enabled <= n_irq_enabled;
                r_wr_ptr      <= r_wr_ptr + PTR_W'(n_nres);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (in_acc ? CNT_W'(n_nres) : CNT_W'(0))
                               - (out_acc ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Result payload storage.
    always_ff @(posedge i_clk) begin
        if (in_acc && n_nres != 2'd0) begin
            r_fifo[r_wr_ptr] <= n_res0;
        end
        if (in_acc && n_nres == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= n_res1;
        end
    end

    assign o_kind           = r_fifo[r_rd_ptr].kind;
    assign o_window_address = r_fifo[r_rd_ptr].window_address;
    assign o_bank_number    = r_fifo[r_rd_ptr].bank_number;
    assign o_chr_in_ram     = r_fifo[r_rd_ptr].chr_in_ram;
    assign o_mirroring      = r_fifo[r_rd_ptr].mirroring;
    assign o_last           = r_fifo[r_rd_ptr].last;

endmodule

// File: src/mmc3c_checker.sv
// Port-level checker for the mapper core, bound to the top level.
// Depends on mmc3c_pkg and mmc3_clone_bank_mapper_irq_core.
module mmc3c_checker
    import mmc3c_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [15:0] o_window_address,
    input logic [7:0]  o_bank_number,
    input logic        o_last
);

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_bank_number)
            && $stable(o_window_address) && $stable(o_last))
        else $error("stalled result changed");

    // Only CHR mappings come in pairs; every other kind closes its input beat.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_CHR |-> o_last)
        else $error("non-CHR result without last");

    // The second half of a 2 KB CHR pair is queued with the first.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && o_last && o_kind == KIND_CHR)
        else $error("CHR pair broken");

    // Mirroring and IRQ results carry no window or bank.
    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_MIR || o_kind == KIND_IRQ)
            |-> o_window_address == 16'd0 && o_bank_number == 8'd0)
        else $error("unused fields not zero");

endmodule

bind mmc3_clone_bank_mapper_irq_core mmc3c_checker u_mmc3c_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_kind           (o_kind),
    .o_window_address (o_window_address),
    .o_bank_number    (o_bank_number),
    .o_last           (o_last)
);
